### design/snm_pkg.sv
// Shared types, constants and state encoding for the sensor min/max normalizer.
// No dependencies; snm_div and the top level import this package.
package snm_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 10;
  localparam int NORM_W   = 10;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel_out;
    logic [NORM_W-1:0]   normalized;
    logic                span_invalid;
    logic [SAMPLE_W-1:0] min_now;
    logic [SAMPLE_W-1:0] max_now;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_MUL,
    S_START,
    S_WAIT,
    S_DONE
  } snm_state_t;

endpackage

### design/snm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module snm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/snm_div.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
// Depends on snm_pkg for the quotient width.
module snm_div import snm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [SAMPLE_BITS+NORM_W-1:0]   dividend,
  input  logic [SAMPLE_BITS-1:0]          divisor,
  output logic                            done,
  output logic [NORM_W-1:0]               quotient
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = SAMPLE_BITS + NORM_W;
  localparam int CW = $clog2(NORM_W + 1);

  logic            busy;
  logic [CW-1:0]   count;
  logic [SB-1:0]   rem;
  logic [SB-1:0]   dvs;
  logic [NORM_W-1:0] low;
  logic [SB:0]     trial;
  logic [SB:0]     trial_sub;
  logic            fits;

  always_comb begin
    trial     = {rem, low[NORM_W-1]};
    fits      = trial >= {1'b0, dvs};
    trial_sub = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(NORM_W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW-1:NORM_W];
      low <= dividend[NORM_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem      <= fits ? trial_sub[SB-1:0] : trial[SB-1:0];
      low      <= {low[NORM_W-2:0], 1'b0};
      quotient <= {quotient[NORM_W-2:0], fits};
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("Divider started while busy.");
  a_rem_below: assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvs)
    else $error("Partial remainder reached the divisor.");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("Divider finished without a running division.");
`endif

endmodule

### design/sensor_min_max_normalizer.sv
// Top level of the per-channel min/max normalizer.
// Depends on snm_pkg, snm_ram and snm_div.
//
// Usage: each input beat on in_data carries a channel number and a raw sample.
// The block updates that channel's running minimum and maximum, then returns
// one output beat with (sample - min) * scale / (max - min), truncated, along
// with the updated min and max. When the span is zero or negative, or the
// channel is beyond the configured channel count, normalized is 0 and
// span_invalid is set.
// The user must write the scale register through cfg_we and cfg_data only
// while idle; the block itself does not enforce this. An accepted beat goes
// to the lookup state; with a valid span it then passes the multiply, divider
// start and wait states, where the ten-step restoring divider runs, before
// the done state; otherwise it goes straight to done. The block takes one
// beat at a time and takes no new beat until done has handed its result on.
// A finished result sits in the output register, so a new beat is accepted
// while the receiver stalls; a second result waits until that register frees.
// Synchronous reset sets scale to 100, every minimum to full scale and every
// maximum to zero, through per-channel valid bits, with no clearing pass.
module sensor_min_max_normalizer import snm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DW    = SAMPLE_BITS + NORM_W;
  localparam int CH_AW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam logic [6:0]    CH_LIM   = 7'(CHANNELS);
  localparam logic [SB-1:0] MIN_INIT = '1;

  snm_state_t state, state_next;

  logic [SCALE_W-1:0]  scale;
  logic [CHANNELS-1:0] ent_valid;
  logic                ent_hit;
  logic [CH_W-1:0]     ch;
  logic [CH_AW-1:0]    ch_idx;
  logic                ch_ok;
  logic [SB-1:0]       s;
  logic [SB-1:0]       lo;
  logic [SB-1:0]       hi;
  logic [SB-1:0]       diff;
  logic [SB-1:0]       span;
  logic                bad;
  logic [DW-1:0]       prod;

  logic                accept;
  logic                out_free;
  logic [CH_AW-1:0]    in_idx;
  logic [2*SB-1:0]     ram_rdata;
  logic [SB-1:0]       cur_min;
  logic [SB-1:0]       cur_max;
  logic [SB-1:0]       lo_new;
  logic [SB-1:0]       hi_new;
  logic                div_start;
  logic                div_done;
  logic [NORM_W-1:0]   quotient;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_idx   = CH_AW'(in_data.channel);

  always_comb begin
    cur_min = ent_hit ? ram_rdata[2*SB-1:SB] : MIN_INIT;
    cur_max = ent_hit ? ram_rdata[SB-1:0] : '0;
    if (s < cur_min) begin
      lo_new = s;
      hi_new = cur_max;
    end else if (s > cur_max) begin
      lo_new = cur_min;
      hi_new = s;
    end else begin
      lo_new = cur_min;
      hi_new = cur_max;
    end
  end

  snm_ram #(
    .WIDTH (2 * SB),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (state == S_LOOKUP && ch_ok),
    .waddr (ch_idx),
    .wdata ({lo_new, hi_new}),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  snm_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = (!ch_ok || !(hi_new > lo_new)) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        state_next = S_START;
      end
      S_START: begin
        div_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (state == S_LOOKUP && ch_ok) begin
      ent_valid[ch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch      <= in_data.channel;
      ch_idx  <= in_idx;
      ch_ok   <= {4'b0, in_data.channel} < CH_LIM;
      s       <= SB'(in_data.sample);
      ent_hit <= ent_valid[in_idx];
    end
    if (state == S_LOOKUP) begin
      lo   <= lo_new;
      hi   <= hi_new;
      diff <= s - lo_new;
      span <= hi_new - lo_new;
      bad  <= !ch_ok || !(hi_new > lo_new);
    end
    if (state == S_MUL) begin
      prod <= DW'(diff) * DW'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.channel_out  <= ch;
      out_data.normalized   <= bad ? '0 : quotient;
      out_data.span_invalid <= bad;
      out_data.min_now      <= ch_ok ? SAMPLE_W'(lo) : '0;
      out_data.max_now      <= ch_ok ? SAMPLE_W'(hi) : '0;
    end
  end

`ifndef SYNTHESIS
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOKUP)
    else $error("Accepted beat did not start a store lookup.");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.span_invalid |-> out_data.normalized == '0)
    else $error("Invalid span produced a nonzero result.");
  a_valid_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.span_invalid |-> out_data.normalized <= scale)
    else $error("Normalized result exceeds scale.");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("Divider finished outside the wait state.");
`endif

endmodule

### dv/sensor_min_max_normalizer_test.sv
// Self-checking testbench for sensor_min_max_normalizer: a directed table, then random
// phases over several scale settings and idle patterns, checked against a local predictor.
// Depends on snm_pkg and the design files; needs nothing else.
module sensor_min_max_normalizer_test;
  import snm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int PHASES = 6;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_data = '0;

  logic [SAMPLE_W-1:0] chan_min [CHANNELS_DEF];
  logic [SAMPLE_W-1:0] chan_max [CHANNELS_DEF];
  logic [SCALE_W-1:0]  scale_now;
  out_item_t           pending_results [$];
  int                  errors = 0;
  int                  send_idle = 0;
  int                  recv_stall = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{3'd0, 12'd0},    1'b1, '{3'd0, 10'd0,   1'b1, 12'd0,    12'd0}},
    '{'{3'd0, 12'd4095}, 1'b1, '{3'd0, 10'd100, 1'b0, 12'd0,    12'd4095}},
    '{'{3'd0, 12'd0},    1'b1, '{3'd0, 10'd0,   1'b0, 12'd0,    12'd4095}},
    '{'{3'd0, 12'd2048}, 1'b0, '0},
    '{'{3'd0, 12'd4094}, 1'b0, '0},
    '{'{3'd7, 12'd4095}, 1'b1, '{3'd7, 10'd0,   1'b1, 12'd4095, 12'd4095}},
    '{'{3'd7, 12'd4095}, 1'b1, '{3'd7, 10'd0,   1'b1, 12'd4095, 12'd4095}},
    '{'{3'd7, 12'd0},    1'b1, '{3'd7, 10'd0,   1'b0, 12'd0,    12'd4095}},
    '{'{3'd3, 12'd1234}, 1'b1, '{3'd3, 10'd0,   1'b1, 12'd1234, 12'd0}},
    '{'{3'd3, 12'd1234}, 1'b1, '{3'd3, 10'd0,   1'b1, 12'd1234, 12'd1234}},
    '{'{3'd3, 12'd1300}, 1'b1, '{3'd3, 10'd100, 1'b0, 12'd1234, 12'd1300}},
    '{'{3'd3, 12'd1250}, 1'b0, '0},
    '{'{3'd3, 12'd1233}, 1'b0, '0},
    '{'{3'd3, 12'd1301}, 1'b0, '0},
    '{'{3'd5, 12'd2730}, 1'b0, '0},
    '{'{3'd5, 12'd1365}, 1'b0, '0},
    '{'{3'd5, 12'd2000}, 1'b0, '0},
    '{'{3'd1, 12'd1},    1'b0, '0},
    '{'{3'd2, 12'd4094}, 1'b0, '0},
    '{'{3'd4, 12'd2048}, 1'b0, '0},
    '{'{3'd6, 12'd100},  1'b0, '0},
    '{'{3'd6, 12'd100},  1'b0, '0}
  };

  int phase_scale [PHASES] = '{1000, 0, 1, -1, -1, 1000};
  int phase_idle  [PHASES] = '{0, 61, 0, 7, 0, 7};
  int phase_stall [PHASES] = '{0, 0, 61, 7, 0, 7};
  int phase_width [PHASES] = '{16, 64, 256, 1024, 2048, 2048};
  int phase_items [PHASES] = '{190, 190, 190, 190, 190, 190};

  sensor_min_max_normalizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic out_item_t normalize_sample(input in_item_t item);
    out_item_t   res;
    logic [31:0] lo;
    logic [31:0] hi;
    res = '0;
    res.channel_out = item.channel;
    if (item.sample < chan_min[item.channel]) begin
      chan_min[item.channel] = item.sample;
    end else if (item.sample > chan_max[item.channel]) begin
      chan_max[item.channel] = item.sample;
    end
    lo = 32'(chan_min[item.channel]);
    hi = 32'(chan_max[item.channel]);
    res.min_now = chan_min[item.channel];
    res.max_now = chan_max[item.channel];
    res.span_invalid = 1'b1;
    if (hi > lo) begin
      res.span_invalid = 1'b0;
      res.normalized = NORM_W'(((32'(item.sample) - lo) * 32'(scale_now)) / (hi - lo));
    end
    return res;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result beat: channel_out %0d", got.channel_out);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.channel_out !== want.channel_out) begin
      $error("channel_out expected %0d actual %0d", want.channel_out, got.channel_out);
      errors++;
    end
    if (got.normalized !== want.normalized) begin
      $error("normalized expected %0d actual %0d", want.normalized, got.normalized);
      errors++;
    end
    if (got.span_invalid !== want.span_invalid) begin
      $error("span_invalid expected %0d actual %0d", want.span_invalid, got.span_invalid);
      errors++;
    end
    if (got.min_now !== want.min_now) begin
      $error("min_now expected %0d actual %0d", want.min_now, got.min_now);
      errors++;
    end
    if (got.max_now !== want.max_now) begin
      $error("max_now expected %0d actual %0d", want.max_now, got.max_now);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_result(out_data);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_sample(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scale_now = value;
  endtask

  initial begin
    in_item_t  item;
    out_item_t predicted;
    int        row;
    int        phase;
    int        idx;
    int        width;
    for (idx = 0; idx < CHANNELS_DEF; idx++) begin
      chan_min[idx] = '1;
      chan_max[idx] = '0;
    end
    scale_now = SCALE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_sample(directed_rows[row].item);
      predicted = normalize_sample(directed_rows[row].item);
      pending_results.push_back(directed_rows[row].typed ? directed_rows[row].result
                                                         : predicted);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain_and_settle();
      send_idle  = phase_idle[phase];
      recv_stall = phase_stall[phase];
      if (phase_scale[phase] < 0) begin
        write_scale(SCALE_W'($urandom_range(1, 1000)));
      end else begin
        write_scale(SCALE_W'(phase_scale[phase]));
      end
      width = phase_width[phase];
      for (idx = 0; idx < phase_items[phase]; idx++) begin
        sender_gap();
        item.channel = CH_W'($urandom_range(0, CHANNELS_DEF - 1));
        item.sample  = SAMPLE_W'(2048 - width + $urandom_range(0, 2 * width - 1));
        if (phase == PHASES - 1 && $urandom_range(0, 15) == 0) begin
          item.sample = $urandom_range(0, 1) ? '1 : '0;
        end
        send_sample(item);
        pending_results.push_back(normalize_sample(item));
        if (phase == 3 && idx == phase_items[phase] / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_results.size() != 0);
        end
      end
    end

    drain_and_settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
